[rtl/core/stw_pkg.sv]
// Shared types, constants and digit helpers for the stopwatch display core.
package stw_pkg;

	localparam int unsigned TICK_W   = 16;
	localparam int unsigned SEC_W    = 6;
	localparam int unsigned MIN_W    = 7;
	localparam int unsigned EDGE_W   = 4;
	localparam int unsigned SEG_W    = 32;
	localparam int unsigned IN_TDATA_W  = 8;
	localparam int unsigned OUT_TDATA_W = 48;

	localparam int unsigned PLAY_BIT = 3;
	localparam int unsigned NEXT_BIT = 2;
	localparam int unsigned PREV_BIT = 1;

	localparam logic [SEC_W-1:0] SEC_PER_MIN = SEC_W'(60);
	localparam logic [MIN_W-1:0] MIN_WRAP    = MIN_W'(100);

	typedef struct packed {
		logic [TICK_W-1:0] tick_count;
		logic [SEC_W-1:0]  second_count;
		logic [MIN_W-1:0]  minute_count;
		logic              running;
	} stw_state_t;

	typedef struct packed {
		logic [SEG_W-1:0] segments;
		logic [MIN_W-1:0] minutes_shown;
		logic [SEC_W-1:0] seconds_shown;
		logic             running_now;
	} stw_result_t;

	// Active-low glyphs, gfedcba
	function automatic logic [7:0] glyph(input logic [3:0] d);
		logic [7:0] g;
		case (d)
			4'd0:    g = 8'h40;
			4'd1:    g = 8'h79;
			4'd2:    g = 8'h24;
			4'd3:    g = 8'h30;
			4'd4:    g = 8'h19;
			4'd5:    g = 8'h12;
			4'd6:    g = 8'h02;
			4'd7:    g = 8'h78;
			4'd8:    g = 8'h00;
			4'd9:    g = 8'h10;
			default: g = 8'h40;
		endcase
		return g;
	endfunction

	// Tens digit of a value below 128: (v * 205) >> 11
	function automatic logic [3:0] tens_of(input logic [MIN_W-1:0] v);
		logic [14:0] p;
		p = 15'(v) * 15'd205;
		return p[14:11];
	endfunction

endpackage

[rtl/core/stw_update.sv]
// Next-state logic: button handling and tick/second/minute rollover.
module stw_update (
	input  stw_pkg::stw_state_t              cur,
	input  logic [stw_pkg::EDGE_W-1:0]       button_edges,
	input  logic                             tick,
	input  logic [stw_pkg::TICK_W-1:0]       ticks_per_second,
	output stw_pkg::stw_state_t              nxt
);

	stw_pkg::stw_state_t       btn;
	logic [stw_pkg::TICK_W:0]  tick_inc;
	logic [stw_pkg::SEC_W-1:0] sec_inc;
	logic [stw_pkg::MIN_W-1:0] min_inc;

	always_comb begin
		btn = cur;
		if (button_edges[stw_pkg::PLAY_BIT]) begin
			btn.running = ~cur.running;
		end else if (button_edges[stw_pkg::NEXT_BIT] || button_edges[stw_pkg::PREV_BIT]) begin
			btn.tick_count   = '0;
			btn.second_count = '0;
			btn.minute_count = '0;
			btn.running      = 1'b1;
		end

		tick_inc = {1'b0, btn.tick_count} + 1'b1;
		sec_inc  = btn.second_count + 1'b1;
		min_inc  = btn.minute_count + 1'b1;

		nxt = btn;
		if (tick && btn.running) begin
			if (tick_inc >= {1'b0, ticks_per_second}) begin
				nxt.tick_count = '0;
				if (sec_inc >= stw_pkg::SEC_PER_MIN) begin
					nxt.second_count = '0;
					nxt.minute_count = (min_inc >= stw_pkg::MIN_WRAP) ? '0 : min_inc;
				end else begin
					nxt.second_count = sec_inc;
				end
			end else begin
				nxt.tick_count = tick_inc[stw_pkg::TICK_W-1:0];
			end
		end
	end

endmodule

[rtl/core/stw_seg.sv]
// MM:SS to four active-low seven-segment bytes.
module stw_seg (
	input  logic [stw_pkg::MIN_W-1:0] minutes,
	input  logic [stw_pkg::SEC_W-1:0] seconds,
	output logic [stw_pkg::SEG_W-1:0] segments
);

	logic [3:0] m_tens, m_units, s_tens, s_units;

	always_comb begin
		m_tens  = stw_pkg::tens_of(minutes);
		m_units = 4'(minutes - 7'(m_tens) * 7'd10);
		s_tens  = stw_pkg::tens_of(stw_pkg::MIN_W'(seconds));
		s_units = 4'(seconds - 6'(s_tens) * 6'd10);
		segments = {stw_pkg::glyph(m_tens), stw_pkg::glyph(m_units),
			stw_pkg::glyph(s_tens), stw_pkg::glyph(s_units)};
	end

endmodule

[rtl/core/stopwatch_seven_segment_core.sv]
// Stopwatch core: input register, counter update, segment encode, result register.
//
// Input stream s_axis: one transfer per event carries the captured button edges
// and the timer tick flag. Each input transfer yields exactly one output
// transfer on m_axis with the MM:SS segment bytes, the minute and second
// counts and the running flag as they stand after that event.
// The cfg channel loads ticks_per_second; cfg_ready is always high. Write it
// only while no transfer is in flight.
// An accepted input is registered in the input stage; its result is registered
// in the result stage and presented on m_axis. Throughput is one item per cycle
// while m_axis_tready is high: the counter update and the segment encode sit
// between the input and result registers, and both stages then advance together.
// When m_axis_tready is low and a result is held, an empty input stage still
// takes one more item; after that s_axis_tready drops until the result moves.
// Reset clears both stages, sets time to 00:00 with running on and loads
// ticks_per_second with TICKS_RESET.
module stopwatch_seven_segment_core #(
	parameter logic [15:0] TICKS_RESET = 16'd1000
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [3:0] button_edges, [4] tick, [7:5] zero
	input  logic [stw_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [31:0] segments, [38:32] minutes_shown, [44:39] seconds_shown, [45] running_now
	output logic [stw_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [15:0]                        cfg_data
);

	logic [stw_pkg::TICK_W-1:0] tps_q;
	stw_pkg::stw_state_t        state_q, state_nxt;
	stw_pkg::stw_result_t       res_q;
	logic [stw_pkg::SEG_W-1:0]  seg_nxt;
	logic                       valid_s1;
	logic [stw_pkg::EDGE_W-1:0] edges_s1;
	logic                       tick_s1;
	logic                       out_valid_q;
	logic                       advance;

	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TICKS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tps_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			edges_s1 <= s_axis_tdata[3:0];
			tick_s1  <= s_axis_tdata[4];
		end
	end

	stw_update u_update (
		.cur              (state_q),
		.button_edges     (edges_s1),
		.tick             (tick_s1),
		.ticks_per_second (tps_q),
		.nxt              (state_nxt)
	);

	stw_seg u_seg (
		.minutes  (state_nxt.minute_count),
		.seconds  (state_nxt.second_count),
		.segments (seg_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.tick_count   <= '0;
			state_q.second_count <= '0;
			state_q.minute_count <= '0;
			state_q.running      <= 1'b1;
			out_valid_q          <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q.segments      <= seg_nxt;
			res_q.minutes_shown <= state_nxt.minute_count;
			res_q.seconds_shown <= state_nxt.second_count;
			res_q.running_now   <= state_nxt.running;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, res_q.running_now, res_q.seconds_shown,
		res_q.minutes_shown, res_q.segments};

	a_sec_range : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (res_q.seconds_shown < stw_pkg::SEC_PER_MIN))
		else $error("seconds out of range");

	a_min_range : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (res_q.minutes_shown < stw_pkg::MIN_WRAP))
		else $error("minutes out of range");

	a_play_toggle : assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && edges_s1[stw_pkg::PLAY_BIT])
		|=> (state_q.running != $past(state_q.running)))
		else $error("play did not toggle running");

	a_clear : assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && !edges_s1[stw_pkg::PLAY_BIT] && !tick_s1
		&& (edges_s1[stw_pkg::NEXT_BIT] || edges_s1[stw_pkg::PREV_BIT]))
		|=> (state_q.second_count == '0 && state_q.minute_count == '0
		&& state_q.tick_count == '0 && state_q.running))
		else $error("clear did not reset counters");

endmodule
